// File: rtl/voltage_current_alarm_qualifier_macros.svh
// assertion macros for the alarm qualifier
`ifndef VOLTAGE_CURRENT_ALARM_QUALIFIER_MACROS_SVH
`define VOLTAGE_CURRENT_ALARM_QUALIFIER_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define VCAQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vcaq assertion failed");
// checked at every edge, reset included
`define VCAQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("vcaq assertion failed");
`else
`define VCAQ_ASSERT(lbl, clk, rst_n, prop)
`define VCAQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/vcaq_pkg.sv
package vcaq_pkg;

    // register indexes
    localparam logic [2:0] REG_OVER_V   = 3'd0;
    localparam logic [2:0] REG_UNDER_V  = 3'd1;
    localparam logic [2:0] REG_OVER_C   = 3'd2;
    localparam logic [2:0] REG_V_HOLD   = 3'd3;
    localparam logic [2:0] REG_C_HOLD   = 3'd4;
    localparam logic [2:0] REG_GATE_EN  = 3'd5;

    // channel kinds
    localparam logic [2:0] KIND_UNUSED  = 3'd0;
    localparam logic [2:0] KIND_VOLT    = 3'd1;
    localparam logic [2:0] KIND_WIDE    = 3'd2;
    localparam logic [2:0] KIND_DC      = 3'd3;
    localparam logic [2:0] KIND_CURRENT = 3'd4;

    // alarm codes
    localparam logic [1:0] ALARM_NORMAL = 2'd0;
    localparam logic [1:0] ALARM_OVER   = 2'd1;
    localparam logic [1:0] ALARM_UNDER  = 2'd2;
    localparam logic [1:0] ALARM_LOSS   = 2'd3;

    localparam logic [5:0] GATE_ALL      = 6'h3F;
    localparam logic [2:0] GATE_FIRST_CH = 3'd3;
    localparam logic [3:0] COUNT_MAX     = 4'd15;

    // wide-range scaling by 380/220, reduced to 19/11, divide by reciprocal
    localparam longint unsigned WIDE_NUM   = 380;
    localparam longint unsigned WIDE_DEN   = 220;
    localparam longint unsigned WIDE_GCD   = 20;
    localparam logic [15:0]     WIDE_LIMIT = 16'd300;
    localparam int              WIDE_SHIFT = 25;
    localparam longint unsigned WIDE_RECIP =
        ((64'd1 << WIDE_SHIFT) + (WIDE_DEN / WIDE_GCD) - 1) / (WIDE_DEN / WIDE_GCD);
    localparam logic [25:0]     WIDE_MUL   = 26'((WIDE_NUM / WIDE_GCD) * WIDE_RECIP);

    typedef struct packed {
        logic        scan_start;
        logic [2:0]  channel;
        logic [2:0]  channel_kind;
        logic [15:0] sample;
        logic [5:0]  gate_status;
    } t_in;

    typedef struct packed {
        logic [2:0] channel_out;
        logic [1:0] alarm_state;
        logic [3:0] active_count;
    } t_out;

    typedef struct packed {
        logic [15:0] prev;
        logic [7:0]  over_cd;
        logic [7:0]  under_cd;
        logic [1:0]  alarm;
    } t_chan_state;

    typedef struct packed {
        logic [15:0] over_v;
        logic [15:0] under_v;
        logic [15:0] over_c;
        logic [7:0]  v_hold;
        logic [7:0]  c_hold;
        logic        wide_en;
        logic [16:0] wide_over;
        logic [16:0] wide_under;
    } t_limits;

endpackage

// File: rtl/vcaq_chan_eval.sv
module vcaq_chan_eval
    import vcaq_pkg::*;
(
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_sample,
    input  logic        i_suppress,
    input  t_chan_state i_state,
    input  t_limits     i_lim,
    output t_chan_state o_state
);

    logic [16:0] w_gy;
    logic [16:0] w_qy;
    logic [16:0] w_qx;
    logic [16:0] w_now;
    logic [16:0] w_was;
    logic [15:0] w_half_c;

    always_comb begin
        if (i_kind == KIND_WIDE && i_lim.wide_en) begin
            w_gy = i_lim.wide_over;
            w_qy = i_lim.wide_under;
        end else begin
            w_gy = {1'b0, i_lim.over_v};
            w_qy = {1'b0, i_lim.under_v};
        end
        w_qx     = w_qy >> 1;
        w_now    = {1'b0, i_sample};
        w_was    = {1'b0, i_state.prev};
        w_half_c = i_lim.over_c >> 1;
    end

    always_comb begin
        o_state = i_state;
        if (i_suppress) begin
            o_state.over_cd  = i_lim.v_hold;
            o_state.under_cd = i_lim.v_hold;
        end else begin
            o_state.prev = i_sample;
            case (i_kind) inside
                KIND_VOLT, KIND_WIDE, KIND_DC: begin
                    if (w_now <= w_qx && w_was <= w_qx) begin
                        o_state.alarm    = ALARM_LOSS;
                        o_state.over_cd  = i_lim.v_hold;
                        o_state.under_cd = i_lim.v_hold;
                    end else if (w_now > w_gy && w_was > w_gy) begin
                        if (i_state.over_cd == 8'd0) begin
                            o_state.alarm = ALARM_OVER;
                        end else begin
                            o_state.over_cd = i_state.over_cd - 8'd1;
                        end
                        o_state.under_cd = i_lim.v_hold;
                    end else if (w_now < w_qy && w_was < w_qy) begin
                        if (i_state.under_cd == 8'd0) begin
                            o_state.alarm = ALARM_UNDER;
                        end else begin
                            o_state.under_cd = i_state.under_cd - 8'd1;
                        end
                        o_state.over_cd = i_lim.v_hold;
                    end else begin
                        o_state.alarm    = ALARM_NORMAL;
                        o_state.over_cd  = i_lim.v_hold;
                        o_state.under_cd = i_lim.v_hold;
                    end
                end
                KIND_CURRENT: begin
                    if (i_sample > i_lim.over_c && i_state.prev > i_lim.over_c) begin
                        if (i_state.over_cd == 8'd0) begin
                            o_state.alarm = ALARM_OVER;
                        end else begin
                            o_state.over_cd = i_state.over_cd - 8'd1;
                        end
                        o_state.under_cd = i_lim.c_hold;
                    end else if (i_sample < w_half_c && i_state.prev < w_half_c) begin
                        o_state.alarm    = ALARM_NORMAL;
                        o_state.over_cd  = i_lim.c_hold;
                        o_state.under_cd = i_lim.c_hold;
                    end
                    // otherwise, e.g. between half the limit and the limit, alarm and countdowns are kept
                end
                default: begin
                    // unused kind: alarm and countdowns kept
                end
            endcase
        end
    end

endmodule

// File: rtl/voltage_current_alarm_qualifier.sv
// channel  | direction | handshake              | beat
// ---------+-----------+------------------------+-------------------------------
// in       | input     | i_in_valid/o_in_ready  | t_in: scan flag, channel, sample
// out      | output    | o_out_valid/i_out_ready| t_out: channel, alarm, count
// cfg      | input     | i_cfg_valid/o_cfg_ready| register index and write data
//
// one beat per cycle sustained while the output is not stalled; an accepted
// beat is captured in the input register, is evaluated against its channel's
// state and lands in the output register, where its result is presented.
// the per-channel read-modify-write is done in the same cycle as the evaluation.
// reset clears all channel state, the scan count and the config registers at once.
// a stalled output holds the input register; one further beat can wait there.
`include "voltage_current_alarm_qualifier_macros.svh"

module voltage_current_alarm_qualifier
    import vcaq_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // the channel field is three bits wide, so at most eight channels hold state
    localparam int SLOTS = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [15:0] r_over_v;
    logic [15:0] r_under_v;
    logic [15:0] r_over_c;
    logic [7:0]  r_v_hold;
    logic [7:0]  r_c_hold;
    logic        r_gate_en;
    logic        r_wide_en;
    logic [16:0] r_wide_over;
    logic [16:0] r_wide_under;

    logic        r_in_valid;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;
    logic [3:0]  r_total;
    t_chan_state r_state [SLOTS];

    logic        w_advance;
    logic        w_in_range;
    logic [IDX_W-1:0] w_idx;
    logic        w_suppress;
    t_chan_state w_cur;
    t_chan_state w_next;
    t_limits     w_lim;
    logic [3:0]  w_base;
    logic [3:0]  n_total;
    t_out        n_out;
    logic [41:0] w_over_prod;
    logic [41:0] w_under_prod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over_v  <= '0;
            r_under_v <= '0;
            r_over_c  <= '0;
            r_v_hold  <= '0;
            r_c_hold  <= '0;
            r_gate_en <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OVER_V:  r_over_v  <= i_cfg_data;
                REG_UNDER_V: r_under_v <= i_cfg_data;
                REG_OVER_C:  r_over_c  <= i_cfg_data;
                REG_V_HOLD:  r_v_hold  <= i_cfg_data[7:0];
                REG_C_HOLD:  r_c_hold  <= i_cfg_data[7:0];
                REG_GATE_EN: r_gate_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // scaled limits follow the registers in the next cycle, which idle time covers
    assign w_over_prod  = {26'd0, r_over_v} * {16'd0, WIDE_MUL};
    assign w_under_prod = {26'd0, r_under_v} * {16'd0, WIDE_MUL};

    always_ff @(posedge i_clk) begin
        r_wide_en    <= r_over_v < WIDE_LIMIT;
        r_wide_over  <= w_over_prod[WIDE_SHIFT+16:WIDE_SHIFT];
        r_wide_under <= w_under_prod[WIDE_SHIFT+16:WIDE_SHIFT];
    end

    always_comb begin
        w_lim.over_v     = r_over_v;
        w_lim.under_v    = r_under_v;
        w_lim.over_c     = r_over_c;
        w_lim.v_hold     = r_v_hold;
        w_lim.c_hold     = r_c_hold;
        w_lim.wide_en    = r_wide_en;
        w_lim.wide_over  = r_wide_over;
        w_lim.wide_under = r_wide_under;
    end

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    assign w_in_range = 32'(r_in.channel) < SLOTS;
    assign w_idx      = r_in.channel[IDX_W-1:0];
    assign w_cur      = r_state[w_idx];
    assign w_suppress = r_gate_en && (r_in.gate_status != GATE_ALL) &&
                        (r_in.channel >= GATE_FIRST_CH) &&
                        (r_in.channel_kind == KIND_VOLT || r_in.channel_kind == KIND_WIDE);

    vcaq_chan_eval u_eval (
        .i_kind     (r_in.channel_kind),
        .i_sample   (r_in.sample),
        .i_suppress (w_suppress),
        .i_state    (w_cur),
        .i_lim      (w_lim),
        .o_state    (w_next)
    );

    always_comb begin
        w_base  = r_in.scan_start ? 4'd0 : r_total;
        n_total = w_base;
        if (w_in_range && !w_suppress && w_next.alarm != ALARM_NORMAL &&
            w_base != COUNT_MAX) begin
            n_total = w_base + 4'd1;
        end
        n_out.channel_out  = r_in.channel;
        n_out.alarm_state  = w_in_range ? w_next.alarm : ALARM_NORMAL;
        n_out.active_count = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_state[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_total     <= n_total;
                if (w_in_range) begin
                    r_state[w_idx] <= w_next;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `VCAQ_ASSERT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
    `VCAQ_ASSERT(a_adv_out, i_clk, i_rst_n, w_advance |=> o_out_valid)
    `VCAQ_ASSERT(a_cnt_match, i_clk, i_rst_n, o_out_valid |-> o_out_data.active_count == r_total)
    `VCAQ_ASSERT(a_range_norm, i_clk, i_rst_n, o_out_valid && (32'(o_out_data.channel_out) >= SLOTS) |-> o_out_data.alarm_state == ALARM_NORMAL)

endmodule
